// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the dual motor speed controller. Every module that
// uses them has a clock named clk and an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define DMSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent
`define DMSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dmsp_pkg.sv
// ----------------------------------------------------------------------------
// dmsp_pkg
// Shared types, codes and helpers of the dual motor speed controller.
// ----------------------------------------------------------------------------
package dmsp_pkg;

    // APB address width: five registers at 4-byte spacing
    localparam int APB_ADDR_W = 5;

    // Integral step divides by 1/dt = 200, eight quotient bits per cycle
    localparam logic [8:0] DT_INV    = 9'd200;
    localparam int         DIV_BITS  = 8;
    localparam int         DIV_STEPS = 48 / DIV_BITS;
    localparam int         DIV_CNT_W = 3;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_TARGET_ONE = 3'd3,
        REG_TARGET_TWO = 3'd4
    } reg_idx_t;

    // Configuration register contents
    typedef struct packed {
        logic signed [31:0] gain_p;
        logic signed [31:0] gain_i;
        logic signed [31:0] gain_d;
        logic signed [15:0] target_rpm_one;
        logic signed [15:0] target_rpm_two;
    } cfg_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RAW,
        S_SUM,
        S_MPREP,
        S_MLO,
        S_MHI,
        S_MFIN,
        S_FILT,
        S_ERR,
        S_DINIT,
        S_DIV,
        S_INTEG,
        S_CMD,
        S_DRV,
        S_DONE
    } ctrl_state_t;

    // Operand pair of the shared multiplier
    typedef enum logic [2:0] {
        MUL_FILT,
        MUL_SUM,
        MUL_P,
        MUL_I,
        MUL_D
    } mul_sel_t;

    // Accumulator action
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    // Multiplier phase strobes
    typedef struct packed {
        logic prep;
        logic lo;
        logic hi;
        logic fin;
    } mul_ctl_t;

    // Controller to datapath command word
    typedef struct packed {
        logic     start;
        logic     motor;
        logic     raw_ld;
        logic     sum_ld;
        mul_ctl_t mul;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     filt_ld;
        logic     err_ld;
        logic     div_init;
        logic     div_step;
        logic     integ_ld;
        logic     drv_ld;
        logic     out_load;
    } dp_cmd_t;

    // Saturate a signed value to 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic fits;
        fits = (v[63:47] == {17{v[47]}});
        if (fits)
            return v[47:0];
        else if (v[63])
            return 48'sh8000_0000_0000;
        else
            return 48'sh7FFF_FFFF_FFFF;
    endfunction

endpackage

// File: design/dmsp_regs.sv
// ----------------------------------------------------------------------------
// dmsp_regs
// APB register block: PID gains and per-motor target speeds.
// ----------------------------------------------------------------------------
module dmsp_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmsp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output dmsp_pkg::cfg_t                      cfg
);

    dmsp_pkg::cfg_t      cfg_reg;
    dmsp_pkg::reg_idx_t  idx;
    logic                wr_en;

    assign pready = 1'b1;
    assign idx    = dmsp_pkg::reg_idx_t'(paddr[dmsp_pkg::APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                dmsp_pkg::REG_GAIN_P:     cfg_reg.gain_p         <= pwdata;
                dmsp_pkg::REG_GAIN_I:     cfg_reg.gain_i         <= pwdata;
                dmsp_pkg::REG_GAIN_D:     cfg_reg.gain_d         <= pwdata;
                dmsp_pkg::REG_TARGET_ONE: cfg_reg.target_rpm_one <= pwdata[15:0];
                dmsp_pkg::REG_TARGET_TWO: cfg_reg.target_rpm_two <= pwdata[15:0];
                default:                  ;
            endcase
        end
    end

    // Read mux, targets sign extended
    always_comb
    begin
        case (idx)
            dmsp_pkg::REG_GAIN_P:     prdata = cfg_reg.gain_p;
            dmsp_pkg::REG_GAIN_I:     prdata = cfg_reg.gain_i;
            dmsp_pkg::REG_GAIN_D:     prdata = cfg_reg.gain_d;
            dmsp_pkg::REG_TARGET_ONE: prdata = {{16{cfg_reg.target_rpm_one[15]}},
                                                cfg_reg.target_rpm_one};
            dmsp_pkg::REG_TARGET_TWO: prdata = {{16{cfg_reg.target_rpm_two[15]}},
                                                cfg_reg.target_rpm_two};
            default:                  prdata = '0;
        endcase
    end

endmodule

// File: design/dmsp_mul.sv
// ----------------------------------------------------------------------------
// dmsp_mul
// Shared Q-format multiplier: sign-magnitude 32 x 50 bit product built from
// two 32 x 25 bit partial products, shifted by FRAC_BITS, truncated toward
// zero and saturated to 48 bits. Four phases: prep, lo, hi, fin.
// ----------------------------------------------------------------------------
module dmsp_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    clk,
    input  dmsp_pkg::mul_ctl_t      ctl,
    input  logic signed [31:0]      a_op,
    input  logic signed [49:0]      b_op,
    output logic signed [47:0]      q
);

    logic [31:0]        ua_reg;
    logic [49:0]        ub_reg;
    logic               neg_reg;
    logic [56:0]        plo_reg;
    logic [56:0]        phi_reg;
    logic signed [47:0] q_reg;

    logic [81:0]        prod;
    logic [81:0]        prod_q;
    logic [81:0]        lim;
    logic [47:0]        q_mag;
    logic signed [47:0] q_next;

    // Final combine, scale and saturate
    always_comb
    begin
        prod   = {phi_reg, 25'd0} + 82'(plo_reg);
        prod_q = prod >> FRAC_BITS;
        lim    = neg_reg ? (82'd1 << 47) : ((82'd1 << 47) - 82'd1);
        q_mag  = (prod_q > lim) ? lim[47:0] : prod_q[47:0];
        q_next = neg_reg ? (48'sd0 - q_mag) : q_mag;
    end

    // Phase registers
    always_ff @(posedge clk)
    begin
        if (ctl.prep)
        begin
            ua_reg  <= a_op[31] ? (32'd0 - a_op) : a_op;
            ub_reg  <= b_op[49] ? (50'd0 - b_op) : b_op;
            neg_reg <= a_op[31] ^ b_op[49];
        end
        if (ctl.lo)
            plo_reg <= 57'(ua_reg) * 57'(ub_reg[24:0]);
        if (ctl.hi)
            phi_reg <= 57'(ua_reg) * 57'(ub_reg[49:25]);
        if (ctl.fin)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// File: design/dmsp_dp.sv
// ----------------------------------------------------------------------------
// dmsp_dp
// Datapath: per-motor state, speed estimate, IIR filter, PID terms, integral
// divider, drive mapping and the result word register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmsp_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dmsp_pkg::dp_cmd_t   cmd,
    input  dmsp_pkg::cfg_t      cfg,
    input  logic [63:0]         s_tdata,    // position_one, position_two
    output logic [95:0]         m_tdata     // drive_one_a, drive_one_b, drive_two_a,
                                            // drive_two_b, speed_one, speed_two
);

    // Filter coefficients and command limit in Q format
    localparam logic [31:0] COEF_A  = 32'(((64'd854 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [31:0] COEF_B  = 32'(((64'd728 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [49:0] CMD_LIM = 50'(64'd255 << FRAC_BITS);

    // Per-motor state
    logic [31:0]        pos_reg      [2];
    logic [31:0]        last_pos_reg [2];
    logic signed [47:0] filt_st_reg  [2];
    logic signed [47:0] rawp_reg     [2];
    logic signed [47:0] integ_st_reg [2];
    logic signed [47:0] errp_reg     [2];

    // Working registers
    logic signed [47:0] raw_reg;
    logic signed [48:0] sum_reg;
    logic signed [49:0] acc_reg;
    logic signed [47:0] filt_reg;
    logic signed [47:0] err_reg;
    logic signed [47:0] deriv_reg;
    logic signed [47:0] integ_reg;
    logic [47:0]        dq_reg;
    logic [7:0]         rem_reg;
    logic               qneg_reg;

    // Staged results and output word
    logic [7:0]         res_a_reg   [2];
    logic [7:0]         res_b_reg   [2];
    logic [31:0]        res_spd_reg [2];
    logic [95:0]        out_reg;

    logic               m;
    logic [31:0]        delta;
    logic signed [63:0] delta64;
    logic signed [63:0] raw64;
    logic signed [47:0] raw_next;
    logic signed [48:0] sum_next;
    logic signed [47:0] mul_q;
    logic signed [49:0] q50;
    logic signed [47:0] filt_next;
    logic signed [15:0] tgt;
    logic signed [63:0] tgt64;
    logic signed [47:0] err_next;
    logic signed [63:0] dif64;
    logic signed [47:0] deriv_next;
    logic [47:0]        err_abs;
    logic [8:0]         rem_next;
    logic [47:0]        dq_next;
    logic signed [63:0] sq64;
    logic signed [47:0] integ_next;
    logic [49:0]        cmd_abs;
    logic [49:0]        cmd_mag;
    logic [7:0]         duty;
    logic [47:0]        f_abs;
    logic [47:0]        f_int;
    logic [31:0]        spd_next;
    logic signed [31:0] mul_a;
    logic signed [49:0] mul_b;

    assign m     = cmd.motor;
    assign q50   = {{2{mul_q[47]}}, mul_q};

    // Speed estimate: delta * 20 in Q, saturated
    assign delta    = pos_reg[m] - last_pos_reg[m];
    assign delta64  = {{32{delta[31]}}, delta};
    assign raw64    = ((delta64 <<< 4) + (delta64 <<< 2)) <<< FRAC_BITS;
    assign raw_next = dmsp_pkg::sat48(raw64);
    assign sum_next = {raw_reg[47], raw_reg} + {rawp_reg[m][47], rawp_reg[m]};

    // Filter output
    assign filt_next = dmsp_pkg::sat48({{14{acc_reg[49]}}, acc_reg}
                                       + {{16{mul_q[47]}}, mul_q});

    // Speed error
    assign tgt      = m ? cfg.target_rpm_two : cfg.target_rpm_one;
    assign tgt64    = {{48{tgt[15]}}, tgt} <<< FRAC_BITS;
    assign err_next = dmsp_pkg::sat48(tgt64 - {{16{filt_reg[47]}}, filt_reg});

    // Derivative: (err - err_prev) * 200
    assign dif64      = {{16{err_reg[47]}}, err_reg} - {{16{errp_reg[m][47]}}, errp_reg[m]};
    assign deriv_next = dmsp_pkg::sat48((dif64 <<< 7) + (dif64 <<< 6) + (dif64 <<< 3));
    assign err_abs    = err_reg[47] ? (48'd0 - err_reg) : err_reg;

    // Restoring divide by 200, eight quotient bits per step
    always_comb
    begin
        rem_next = {1'b0, rem_reg};
        dq_next  = dq_reg;
        for (int i = 0; i < dmsp_pkg::DIV_BITS; i++)
        begin
            rem_next = {rem_next[7:0], dq_next[47]};
            dq_next  = {dq_next[46:0], 1'b0};
            if (rem_next >= dmsp_pkg::DT_INV)
            begin
                rem_next   = rem_next - dmsp_pkg::DT_INV;
                dq_next[0] = 1'b1;
            end
        end
    end

    // Integrator update
    assign sq64       = qneg_reg ? (64'sd0 - {16'd0, dq_reg}) : {16'd0, dq_reg};
    assign integ_next = dmsp_pkg::sat48({{16{integ_st_reg[m][47]}}, integ_st_reg[m]} + sq64);

    // Command clamp and drive split
    assign cmd_abs = acc_reg[49] ? (50'd0 - acc_reg) : acc_reg;
    assign cmd_mag = (cmd_abs > CMD_LIM) ? CMD_LIM : cmd_abs;
    assign duty    = cmd_mag[FRAC_BITS +: 8];

    // Integer part of filtered speed, toward zero, saturated to 32 bits
    always_comb
    begin
        f_abs = filt_reg[47] ? (48'd0 - filt_reg) : filt_reg;
        f_int = f_abs >> FRAC_BITS;
        if (!filt_reg[47])
            spd_next = (f_int > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : f_int[31:0];
        else
            spd_next = (f_int > 48'h0000_8000_0000) ? 32'h8000_0000
                                                    : (32'd0 - f_int[31:0]);
    end

    // Multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            dmsp_pkg::MUL_FILT:
            begin
                mul_a = COEF_A;
                mul_b = {{2{filt_st_reg[m][47]}}, filt_st_reg[m]};
            end
            dmsp_pkg::MUL_SUM:
            begin
                mul_a = COEF_B;
                mul_b = {sum_reg[48], sum_reg};
            end
            dmsp_pkg::MUL_P:
            begin
                mul_a = cfg.gain_p;
                mul_b = {{2{err_reg[47]}}, err_reg};
            end
            dmsp_pkg::MUL_I:
            begin
                mul_a = cfg.gain_i;
                mul_b = {{2{integ_reg[47]}}, integ_reg};
            end
            dmsp_pkg::MUL_D:
            begin
                mul_a = cfg.gain_d;
                mul_b = {{2{deriv_reg[47]}}, deriv_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    dmsp_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk  (clk),
        .ctl  (cmd.mul),
        .a_op (mul_a),
        .b_op (mul_b),
        .q    (mul_q)
    );

    // Motor state, divider remainder, staged results and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 2; k++)
            begin
                last_pos_reg[k] <= '0;
                filt_st_reg[k]  <= '0;
                rawp_reg[k]     <= '0;
                integ_st_reg[k] <= '0;
                errp_reg[k]     <= '0;
                res_a_reg[k]    <= '0;
                res_b_reg[k]    <= '0;
                res_spd_reg[k]  <= '0;
            end
            rem_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    res_a_reg[k]   <= '0;
                    res_b_reg[k]   <= '0;
                    res_spd_reg[k] <= '0;
                end
            end
            if (cmd.div_init)
                rem_reg <= '0;
            else if (cmd.div_step)
                rem_reg <= rem_next[7:0];
            if (cmd.drv_ld)
            begin
                last_pos_reg[m] <= pos_reg[m];
                filt_st_reg[m]  <= filt_reg;
                rawp_reg[m]     <= raw_reg;
                integ_st_reg[m] <= integ_reg;
                errp_reg[m]     <= err_reg;
                res_a_reg[m]    <= acc_reg[49] ? duty : 8'd0;
                res_b_reg[m]    <= acc_reg[49] ? 8'd0 : duty;
                res_spd_reg[m]  <= spd_next;
            end
            if (cmd.out_load)
                out_reg <= {res_spd_reg[1], res_spd_reg[0],
                            res_b_reg[1], res_a_reg[1], res_b_reg[0], res_a_reg[0]};
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pos_reg[0] <= s_tdata[31:0];
            pos_reg[1] <= s_tdata[63:32];
        end
        if (cmd.raw_ld)
            raw_reg <= raw_next;
        if (cmd.sum_ld)
            sum_reg <= sum_next;
        case (cmd.acc_op)
            dmsp_pkg::ACC_LOAD: acc_reg <= q50;
            dmsp_pkg::ACC_ADD:  acc_reg <= acc_reg + q50;
            default:            ;
        endcase
        if (cmd.filt_ld)
            filt_reg <= filt_next;
        if (cmd.err_ld)
            err_reg <= err_next;
        if (cmd.div_init)
        begin
            dq_reg    <= err_abs;
            qneg_reg  <= err_reg[47];
            deriv_reg <= deriv_next;
        end
        else if (cmd.div_step)
        begin
            dq_reg <= dq_next;
        end
        if (cmd.integ_ld)
            integ_reg <= integ_next;
    end

    assign m_tdata = out_reg;

    `DMSP_ASSERT(a_rem_below_divisor, rem_reg < 8'd200, "divider remainder out of range")
    `DMSP_ASSERT(a_one_channel_one, (out_reg[7:0] == 8'd0) || (out_reg[15:8] == 8'd0),
                 "motor one drives both channels")
    `DMSP_ASSERT(a_one_channel_two, (out_reg[23:16] == 8'd0) || (out_reg[31:24] == 8'd0),
                 "motor two drives both channels")

endmodule

// File: design/dmsp_ctrl.sv
// ----------------------------------------------------------------------------
// dmsp_ctrl
// Sequencer: steps each motor through speed estimate, filter, error, integral
// divide and three PID products on the shared multiplier, then hands the word
// to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dmsp_ctrl #(
    parameter int MOTORS = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output dmsp_pkg::dp_cmd_t   cmd
);

    dmsp_pkg::ctrl_state_t          state_reg;
    dmsp_pkg::ctrl_state_t          state_next;
    logic                           motor_reg;
    logic                           motor_next;
    dmsp_pkg::mul_sel_t             mul_sel_reg;
    dmsp_pkg::mul_sel_t             mul_sel_next;
    logic [dmsp_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [dmsp_pkg::DIV_CNT_W-1:0] div_cnt_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dmsp_pkg::S_IDLE;
            motor_reg     <= 1'b0;
            mul_sel_reg   <= dmsp_pkg::MUL_FILT;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            motor_reg     <= motor_next;
            mul_sel_reg   <= mul_sel_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        motor_next   = motor_reg;
        mul_sel_next = mul_sel_reg;
        div_cnt_next = div_cnt_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.motor    = motor_reg;
        cmd.mul_sel  = mul_sel_reg;
        cmd.acc_op   = dmsp_pkg::ACC_HOLD;

        case (state_reg)
            dmsp_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    motor_next = 1'b0;
                    state_next = dmsp_pkg::S_RAW;
                end
            end
            dmsp_pkg::S_RAW:
            begin
                cmd.raw_ld = 1'b1;
                state_next = dmsp_pkg::S_SUM;
            end
            dmsp_pkg::S_SUM:
            begin
                cmd.sum_ld   = 1'b1;
                mul_sel_next = dmsp_pkg::MUL_FILT;
                state_next   = dmsp_pkg::S_MPREP;
            end
            dmsp_pkg::S_MPREP:
            begin
                cmd.mul.prep = 1'b1;
                // fold the previous product into the accumulator
                case (mul_sel_reg)
                    dmsp_pkg::MUL_SUM: cmd.acc_op = dmsp_pkg::ACC_LOAD;
                    dmsp_pkg::MUL_I:   cmd.acc_op = dmsp_pkg::ACC_LOAD;
                    dmsp_pkg::MUL_D:   cmd.acc_op = dmsp_pkg::ACC_ADD;
                    default:           cmd.acc_op = dmsp_pkg::ACC_HOLD;
                endcase
                state_next = dmsp_pkg::S_MLO;
            end
            dmsp_pkg::S_MLO:
            begin
                cmd.mul.lo = 1'b1;
                state_next = dmsp_pkg::S_MHI;
            end
            dmsp_pkg::S_MHI:
            begin
                cmd.mul.hi = 1'b1;
                state_next = dmsp_pkg::S_MFIN;
            end
            dmsp_pkg::S_MFIN:
            begin
                cmd.mul.fin = 1'b1;
                case (mul_sel_reg)
                    dmsp_pkg::MUL_FILT:
                    begin
                        mul_sel_next = dmsp_pkg::MUL_SUM;
                        state_next   = dmsp_pkg::S_MPREP;
                    end
                    dmsp_pkg::MUL_SUM:
                    begin
                        state_next = dmsp_pkg::S_FILT;
                    end
                    dmsp_pkg::MUL_P:
                    begin
                        mul_sel_next = dmsp_pkg::MUL_I;
                        state_next   = dmsp_pkg::S_MPREP;
                    end
                    dmsp_pkg::MUL_I:
                    begin
                        mul_sel_next = dmsp_pkg::MUL_D;
                        state_next   = dmsp_pkg::S_MPREP;
                    end
                    default:
                    begin
                        state_next = dmsp_pkg::S_CMD;
                    end
                endcase
            end
            dmsp_pkg::S_FILT:
            begin
                cmd.filt_ld = 1'b1;
                state_next  = dmsp_pkg::S_ERR;
            end
            dmsp_pkg::S_ERR:
            begin
                cmd.err_ld = 1'b1;
                state_next = dmsp_pkg::S_DINIT;
            end
            dmsp_pkg::S_DINIT:
            begin
                cmd.div_init = 1'b1;
                div_cnt_next = '0;
                state_next   = dmsp_pkg::S_DIV;
            end
            dmsp_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == dmsp_pkg::DIV_CNT_W'(dmsp_pkg::DIV_STEPS - 1))
                    state_next = dmsp_pkg::S_INTEG;
                else
                    div_cnt_next = div_cnt_reg + dmsp_pkg::DIV_CNT_W'(1);
            end
            dmsp_pkg::S_INTEG:
            begin
                cmd.integ_ld = 1'b1;
                mul_sel_next = dmsp_pkg::MUL_P;
                state_next   = dmsp_pkg::S_MPREP;
            end
            dmsp_pkg::S_CMD:
            begin
                cmd.acc_op = dmsp_pkg::ACC_ADD;
                state_next = dmsp_pkg::S_DRV;
            end
            dmsp_pkg::S_DRV:
            begin
                cmd.drv_ld = 1'b1;
                if (!motor_reg && (MOTORS > 1))
                begin
                    motor_next = 1'b1;
                    state_next = dmsp_pkg::S_RAW;
                end
                else
                begin
                    state_next = dmsp_pkg::S_DONE;
                end
            end
            dmsp_pkg::S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = dmsp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dmsp_pkg::S_IDLE;
            end
        endcase
    end

    // Output word valid
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

    `DMSP_ASSERT_NEXT(a_accept_starts_motor_one, s_tvalid && s_tready,
                      (state_reg == dmsp_pkg::S_RAW) && (motor_reg == 1'b0),
                      "accepted word did not start on motor one")
    `DMSP_ASSERT_NEXT(a_load_sets_valid, cmd.out_load, m_tvalid,
                      "result loaded without valid")
    `DMSP_ASSERT(a_div_cnt_range,
                 div_cnt_reg < dmsp_pkg::DIV_CNT_W'(dmsp_pkg::DIV_STEPS),
                 "divider step count overran")

endmodule

// File: design/dual_motor_speed_pid_top.sv
// ----------------------------------------------------------------------------
// dual_motor_speed_pid_top
// Dual DC motor speed controller: encoder delta to rpm, IIR filter, PID with
// saturating integrator, command clamp and H-bridge channel split.
// ----------------------------------------------------------------------------
// One input word carries both encoder snapshots; one output word returns both
// motors' channel A/B duties and filtered integer rpm. Each motor in turn goes
// through the speed estimate, filter, error and PID steps, five Q products on
// the shared multiplier and the divide-by-200 of the integral step (set-up plus
// six steps), and the result is then loaded into the output register; with
// MOTORS = 1 only motor one is processed. The next word is accepted as soon as
// the previous result sits in the output register, and a result waits there
// until taken. Gains and targets are written over APB at byte address 4*i
// (gain_p, gain_i, gain_d, target_rpm_one, target_rpm_two) and take effect on
// the next word; write them only while the block is idle.
// ----------------------------------------------------------------------------
module dual_motor_speed_pid_top #(
    parameter int FRAC_BITS = 16,
    parameter int MOTORS    = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [63:0]                         s_tdata,   // position_one, position_two
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [95:0]                         m_tdata,   // drive_one_a, drive_one_b,
                                                           // drive_two_a, drive_two_b,
                                                           // speed_one, speed_two
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dmsp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    dmsp_pkg::cfg_t     cfg;
    dmsp_pkg::dp_cmd_t  cmd;

    dmsp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dmsp_ctrl #(
        .MOTORS (MOTORS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    dmsp_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .cfg     (cfg),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule
